// ===== rtl/core/cdq_pkg.sv =====
// Package for the circular deque: sizes, command and status codes,
// and the control bundle handed to every storage cell. No dependencies.
package cdq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_REAR  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_REAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic en;
		cmd_t cmd;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/circular_deque.sv =====
// Top level of the circular deque: a row of cdq_cell slots, front at cell 0,
// plus the result register. Depends on cdq_pkg and cdq_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries cmd and value; output channel
//   out_valid/out_ready carries status, popped_value, now_empty, now_full.
//   Every accepted beat yields exactly one result beat.
//   The result is registered and shows in the cycle after acceptance.
//   Throughput: one beat per cycle while in_ready is high; front ops shift
//   words between neighbor slots, so all four complete in a single step.
//   Pop at the rear selects the last occupied slot through a one-hot pick
//   across the row; pop at the front reads slot 0.
//   in_ready is high while the result register is empty or being drained,
//   so a stalled receiver holds at most one result and then stops input.
//   Reset clears every occupied bit and the result valid flag: the deque
//   starts empty, no result pending. Slot words are not reset.
//   A refused push (full) or pop (empty) leaves the contents unchanged and
//   returns overflow or underflow status with popped_value zero.
module circular_deque import cdq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] popped_value,
	output logic               now_empty,
	output logic               now_full
);

	cmd_t            cmd_c;
	logic            accept;
	logic            is_push;
	logic            is_full;
	logic            is_empty;
	logic            refused;
	word_t           push_word;
	word_t           rear_word;
	word_t           pop_word;
	word_t           cell_word [DEPTH];
	logic [DEPTH-1:0] occ;
	logic [DEPTH-1:0] rear;
	cell_ctrl_t      ctrl;
	status_t         status_d;
	logic            empty_d;
	logic            full_d;

	logic            out_valid_q;
	status_t         status_q;
	word_t           popped_q;
	logic            empty_q;
	logic            full_q;

	assign cmd_c     = cmd_t'(cmd);
	assign in_ready  = ~out_valid_q | out_ready;
	assign accept    = in_valid & in_ready;
	assign is_push   = (cmd_c == CMD_PUSH_FRONT) || (cmd_c == CMD_PUSH_REAR);
	assign is_full   = occ[DEPTH-1];
	assign is_empty  = ~occ[0];
	assign refused   = is_push ? is_full : is_empty;
	assign push_word = DATA_WIDTH'($unsigned(value));
	assign ctrl.en   = accept & ~refused;
	assign ctrl.cmd  = cmd_c;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_word;
		logic  left_occ;
		word_t right_word;
		logic  right_occ;
		if (i == 0) begin : g_first
			assign left_word = push_word;
			assign left_occ  = 1'b1;
		end else begin : g_mid
			assign left_word = cell_word[i-1];
			assign left_occ  = occ[i-1];
		end
		if (i == DEPTH-1) begin : g_last
			assign right_word = '0;
			assign right_occ  = 1'b0;
		end else begin : g_inner
			assign right_word = cell_word[i+1];
			assign right_occ  = occ[i+1];
		end
		cdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.push_word  (push_word),
			.left_word  (left_word),
			.left_occ   (left_occ),
			.right_word (right_word),
			.right_occ  (right_occ),
			.word_q     (cell_word[i]),
			.occ_q      (occ[i]),
			.is_rear    (rear[i])
		);
	end

	always_comb begin
		rear_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_word = rear_word | (cell_word[i] & {DATA_WIDTH{rear[i]}});
		end
	end

	always_comb begin
		status_d = ST_DONE;
		pop_word = '0;
		empty_d  = is_empty;
		full_d   = is_full;
		if (is_push) begin
			if (is_full) begin
				status_d = ST_OVERFLOW;
			end else begin
				empty_d = 1'b0;
				full_d  = occ[DEPTH-2];
			end
		end else begin
			if (is_empty) begin
				status_d = ST_UNDERFLOW;
			end else begin
				pop_word = (cmd_c == CMD_POP_FRONT) ? cell_word[0] : rear_word;
				empty_d  = ~occ[1];
				full_d   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			popped_q <= pop_word;
			empty_q  <= empty_d;
			full_q   <= full_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = 32'(popped_q);
	assign now_empty    = empty_q;
	assign now_full     = full_q;

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		occ[DEPTH-1] |-> occ[0])
		else $error("full row with empty front slot");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_OVERFLOW |-> full_q && !empty_q)
		else $error("overflow reported while not full");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_UNDERFLOW |-> empty_q && !full_q)
		else $error("underflow reported while not empty");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_DONE |-> popped_q == '0)
		else $error("refused beat carries a popped word");

	a_push_fills_front: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_push && !is_full |=> occ[0] && !empty_q)
		else $error("accepted push left the deque empty");

endmodule

// ===== rtl/core/cdq_cell.sv =====
// One deque slot: a word and an occupied bit, shifted to or from its
// neighbors as entries enter and leave at the front. Depends on cdq_pkg.
module cdq_cell import cdq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  word_t      push_word,
	input  word_t      left_word,
	input  logic       left_occ,
	input  word_t      right_word,
	input  logic       right_occ,
	output word_t      word_q,
	output logic       occ_q,
	output logic       is_rear
);

	word_t word_d;
	logic  occ_d;

	assign is_rear = occ_q & ~right_occ;

	always_comb begin
		word_d = word_q;
		occ_d  = occ_q;
		if (ctrl.en) begin
			unique case (ctrl.cmd)
				CMD_PUSH_FRONT: begin
					word_d = left_word;
					occ_d  = left_occ;
				end
				CMD_PUSH_REAR: begin
					if (!occ_q && left_occ) begin
						word_d = push_word;
						occ_d  = 1'b1;
					end
				end
				CMD_POP_FRONT: begin
					word_d = right_word;
					occ_d  = right_occ;
				end
				CMD_POP_REAR: begin
					if (is_rear) occ_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) occ_q <= 1'b0;
		else         occ_q <= occ_d;
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

endmodule

// ===== bench/circular_deque_test.sv =====
// Self-checking testbench for circular_deque: a directed table, then random
// fill/drain bursts, most under sender gaps and receiver stalls, scored by an
// in-bench ring predictor or pinned rows. Depends on cdq_pkg, circular_deque.
module circular_deque_test import cdq_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_PER_PHASE = 384;
	localparam int MAX_GAP = 30;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		status_t     st;
		logic [31:0] popped;
		logic        emp;
		logic        ful;
	} deque_result_t;

	typedef struct packed {
		logic          pinned;
		deque_result_t res;
	} pin_t;

	typedef struct packed {
		cmd_t        op;
		logic [31:0] word;
		logic        pinned;
		status_t     st;
		logic [31:0] popped;
		logic        emp;
		logic        ful;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         cmd = CMD_PUSH_FRONT;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] popped_value;
	logic               now_empty;
	logic               now_full;

	circular_deque i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.popped_value (popped_value),
		.now_empty    (now_empty),
		.now_full     (now_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ring predictor state
	logic [31:0] slot_word [DEPTH];
	int          front_ptr = 0;
	int          rear_ptr = 0;
	logic        is_empty = 1'b1;

	deque_result_t expected_q [$];
	pin_t          pinned_q [$];
	plan_row_t     directed_plan [DIRECTED_ROWS];

	int send_idle_pct = 17;
	int recv_stall_pct = 45;
	int mismatches = 0;
	int beats_sent = 0;
	int results_checked = 0;
	int overflow_seen = 0;
	int underflow_seen = 0;
	int full_seen = 0;

	function automatic int ring_next(int p);
		return (p == DEPTH - 1) ? 0 : p + 1;
	endfunction

	function automatic int ring_prev(int p);
		return (p == 0) ? DEPTH - 1 : p - 1;
	endfunction

	function automatic deque_result_t deque_step(cmd_t op, logic [31:0] word);
		deque_result_t r;
		logic          was_full;
		r = '{ST_DONE, 32'h0, 1'b0, 1'b0};
		was_full = !is_empty && ring_next(rear_ptr) == front_ptr;
		if (op == CMD_PUSH_FRONT || op == CMD_PUSH_REAR) begin
			if (was_full) begin
				r.st = ST_OVERFLOW;
			end else if (is_empty) begin
				front_ptr = 0;
				rear_ptr = 0;
				slot_word[0] = word;
				is_empty = 1'b0;
			end else if (op == CMD_PUSH_FRONT) begin
				front_ptr = ring_prev(front_ptr);
				slot_word[front_ptr] = word;
			end else begin
				rear_ptr = ring_next(rear_ptr);
				slot_word[rear_ptr] = word;
			end
		end else begin
			if (is_empty) begin
				r.st = ST_UNDERFLOW;
			end else begin
				r.popped = (op == CMD_POP_FRONT) ? slot_word[front_ptr]
					: slot_word[rear_ptr];
				if (front_ptr == rear_ptr) begin
					is_empty = 1'b1;
					front_ptr = 0;
					rear_ptr = 0;
				end else if (op == CMD_POP_FRONT) begin
					front_ptr = ring_next(front_ptr);
				end else begin
					rear_ptr = ring_prev(rear_ptr);
				end
			end
		end
		r.emp = is_empty;
		r.ful = !is_empty && ring_next(rear_ptr) == front_ptr;
		return r;
	endfunction

	task automatic send_beat(cmd_t op, logic [31:0] word, pin_t pin);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pinned_q.push_back(pin);
		in_valid <= 1'b1;
		cmd <= op;
		value <= word;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// scoreboard: predict on input beats, compare on output beats
	always @(posedge clk) begin
		pin_t          pin;
		deque_result_t want;
		deque_result_t got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = deque_step(cmd_t'(cmd), value);
				pin = pinned_q.pop_front();
				if (pin.pinned)
					want = pin.res;
				if (want.st == ST_OVERFLOW)
					overflow_seen++;
				if (want.st == ST_UNDERFLOW)
					underflow_seen++;
				if (want.ful)
					full_seen++;
				expected_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				got = '{status_t'(status), popped_value, now_empty, now_full};
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: st=%0d pop=%h e=%b f=%b",
							got.st, got.popped, got.emp, got.ful);
				end else begin
					want = expected_q.pop_front();
					results_checked++;
					if (got.st !== want.st || got.popped !== want.popped ||
						got.emp !== want.emp || got.ful !== want.ful) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch at result %0d: expected st=%0d pop=%h e=%b f=%b",
								results_checked, want.st, want.popped, want.emp, want.ful);
							$display("  got st=%0d pop=%h e=%b f=%b",
								got.st, got.popped, got.emp, got.ful);
						end
					end
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("circular_deque_test: done, errors");
		$finish;
	end

	initial begin
		plan_row_t   row;
		cmd_t        op;
		logic [31:0] word;
		int          left;
		int          burst;
		int          mood;
		int          roll;
		int          waited;
		logic        do_push;

		directed_plan = '{
			'{CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_UNDERFLOW, 32'h0, 1'b1, 1'b0},
			'{CMD_POP_REAR,   32'h0000_0005, 1'b1, ST_UNDERFLOW, 32'h0, 1'b1, 1'b0},
			'{CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_DONE,      32'h0, 1'b0, 1'b0},
			'{CMD_POP_REAR,   32'hFFFF_FFFF, 1'b1, ST_DONE, 32'h8000_0000, 1'b1, 1'b0},
			'{CMD_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, ST_DONE,      32'h0, 1'b0, 1'b0},
			'{CMD_POP_FRONT,  32'h0000_0000, 1'b1, ST_DONE, 32'h7FFF_FFFF, 1'b1, 1'b0},
			'{CMD_PUSH_REAR,  32'hFFFF_FFFF, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_FRONT, 32'h0000_0000, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_REAR,  32'hAAAA_AAAA, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_FRONT, 32'h5555_5555, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_REAR,  32'h0000_0001, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_FRONT, 32'h8000_0000, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_REAR,  32'h7FFF_FFFF, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_FRONT, 32'hFFFF_FFFE, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_REAR,  32'h1234_5678, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_FRONT, 32'h8765_4321, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_REAR,  32'h0F0F_0F0F, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_REAR,  32'h1357_9BDF, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_FRONT, 32'h2468_ACE0, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_REAR,  32'h3C3C_3C3C, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_FRONT, 32'hC3C3_C3C3, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0},
			'{CMD_PUSH_FRONT, 32'h0000_0001, 1'b1, ST_OVERFLOW,  32'h0, 1'b0, 1'b1},
			'{CMD_PUSH_REAR,  32'hFFFF_FFFF, 1'b1, ST_OVERFLOW,  32'h0, 1'b0, 1'b1},
			'{CMD_POP_FRONT,  32'h0000_0000, 1'b0, ST_DONE, 32'h0, 1'b0, 1'b0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			send_beat(row.op, row.word,
				'{row.pinned, '{row.st, row.popped, row.emp, row.ful}});
		end

		// random fill/drain bursts; phases 0 and 1 swap who idles, phase 2 never idles
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 17; recv_stall_pct = 45; end
				1: begin send_idle_pct = 45; recv_stall_pct = 17; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			left = RANDOM_PER_PHASE;
			while (left > 0) begin
				burst = $urandom_range(40, 8);
				mood = $urandom_range(2);
				for (int k = 0; k < burst && left > 0; k++) begin
					roll = $urandom_range(99);
					case (mood)
						0: do_push = (roll < 90);
						1: do_push = (roll < 10);
						default: do_push = (roll < 50);
					endcase
					if (do_push)
						op = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
					else
						op = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
					case ($urandom_range(7))
						0: word = 32'h0000_0000;
						1: word = 32'hFFFF_FFFF;
						2: word = 32'h8000_0000;
						3: word = 32'h7FFF_FFFF;
						default: word = $urandom;
					endcase
					send_beat(op, word, '0);
					left--;
				end
			end
		end
		in_valid <= 1'b0;

		waited = 0;
		while (expected_q.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			mismatches += expected_q.size();
			$display("%0d expected result beats never arrived", expected_q.size());
		end

		$display("%0d beats in, %0d results scored, %0d mismatches", beats_sent,
			results_checked, mismatches);
		$display("refused: %0d overflow, %0d underflow; full reported %0d times",
			overflow_seen, underflow_seen, full_seen);
		if (mismatches == 0) begin
			$display("circular_deque_test: done, clean");
		end else begin
			$display("circular_deque_test: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/cdq_pkg.sv
rtl/core/cdq_cell.sv
rtl/core/circular_deque.sv
bench/circular_deque_test.sv
